// ===== rtl/core/bankers_safety_check_assert.svh =====
// Assertion macros for the banker's safety check block.
`ifndef BANKERS_SAFETY_CHECK_ASSERT_SVH
`define BANKERS_SAFETY_CHECK_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsc_pkg.sv =====
// Shared types and constants for the banker's safety check block.
package bsc_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int MAX_RESOURCES_DEF = 16;
  localparam int AMOUNT_BITS_DEF   = 16;

  localparam int CFG_BITS   = 5;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Register select, taken from paddr[2]
  localparam logic REG_NUM_PROC = 1'b0;
  localparam logic REG_NUM_RES  = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLAIM = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_AVAIL = 2'd2,
    KIND_RUN   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic run_init;
    logic rd_chk;
    logic next_r;
    logic next_p;
    logic pick;
    logic rd_add;
    logic wr_add;
    logic rescan;
    logic rd_ord;
    logic emit;
    logic emit_dead;
  } cmd_t;

  typedef struct packed {
    logic p_done;
    logic p_flag;
    logic r_last;
    logic fits;
    logic all_done;
    logic p_last;
  } stat_t;

endpackage

// ===== rtl/core/bsc_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module bsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bsc_ctrl.sv =====
// Control state machine: sequences loads, the safety scan, releases and result output.
module bsc_ctrl import bsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] kind,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_RUN) begin
            cmd.run_init = 1'b1;
            state_next   = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.p_done) begin
          // No process picked in this pass: the run is over
          if (stat.all_done) begin
            cmd.rescan = 1'b1;
            state_next = ST_EMIT_RD;
          end else begin
            cmd.emit_dead = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (stat.p_flag) begin
          cmd.next_p = 1'b1;
        end else begin
          cmd.rd_chk = 1'b1;
          state_next = ST_CHK_CMP;
        end
      end
      ST_CHK_RD: begin
        cmd.rd_chk = 1'b1;
        state_next = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (!stat.fits) begin
          cmd.next_p = 1'b1;
          state_next = ST_SCAN;
        end else if (stat.r_last) begin
          cmd.pick   = 1'b1;
          state_next = ST_ADD_RD;
        end else begin
          cmd.next_r = 1'b1;
          state_next = ST_CHK_RD;
        end
      end
      ST_ADD_RD: begin
        cmd.rd_add = 1'b1;
        state_next = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.wr_add = 1'b1;
        if (stat.r_last) begin
          // Restart from the lowest process after every release
          cmd.rescan = 1'b1;
          state_next = ST_SCAN;
        end else begin
          cmd.next_r = 1'b1;
          state_next = ST_ADD_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_ord = 1'b1;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd.emit = 1'b1;
        if (stat.p_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.next_p = 1'b1;
          state_next = ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bsc_dp.sv =====
// Datapath: claim, allocation, available and order stores, counters, need compare, results.
module bsc_dp import bsc_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
  parameter int AMOUNT_BITS   = AMOUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [1:0]          kind,
  input  logic [3:0]          process,
  input  logic [3:0]          resource,
  input  logic [15:0]         amount,
  input  logic [CFG_BITS-1:0] cfg_np,
  input  logic [CFG_BITS-1:0] cfg_nr,
  output logic                result_valid,
  output logic                verdict,
  output logic [3:0]          process_res,
  output logic                last
);

  localparam int AVAIL_BITS = AMOUNT_BITS + 5;
  localparam int PW         = $clog2(MAX_PROCESSES);
  localparam int PCW        = $clog2(MAX_PROCESSES + 1);
  localparam int RW         = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RCW        = $clog2(MAX_RESOURCES + 1);
  localparam int SDEPTH     = MAX_PROCESSES * MAX_RESOURCES;
  localparam int SAW        = $clog2(SDEPTH);

  logic [PCW-1:0]           p, count, np;
  logic [RCW-1:0]           r, nr;
  logic [MAX_PROCESSES-1:0] flags;
  logic [PW-1:0]            p_idx;
  logic [RW-1:0]            r_idx;

  logic [31:0]              amt_wide, ld_addr_wide, run_addr_wide, ld_res_wide, ord_wide;
  logic [AMOUNT_BITS-1:0]   amt;
  logic                     ld_proc_ok, ld_res_ok;
  logic [SAW-1:0]           ld_addr, run_addr;
  logic [RW-1:0]            ld_res_idx;

  logic                     claim_we, alloc_we, avail_we, store_re;
  logic [AMOUNT_BITS-1:0]   claim_rd, alloc_rd;
  logic [AVAIL_BITS-1:0]    avail_rd, avail_wdata, avail_sum;
  logic [RW-1:0]            avail_waddr;
  logic [PW-1:0]            ord_rd;

  logic signed [AMOUNT_BITS:0] need;
  logic signed [AVAIL_BITS:0]  need_x, avail_x;

  // Clamp the configured counts into 1..max
  always_comb begin
    if (cfg_np == '0) begin
      np = PCW'(1);
    end else if (32'(cfg_np) > 32'(MAX_PROCESSES)) begin
      np = PCW'(MAX_PROCESSES);
    end else begin
      np = PCW'(cfg_np);
    end
    if (cfg_nr == '0) begin
      nr = RCW'(1);
    end else if (32'(cfg_nr) > 32'(MAX_RESOURCES)) begin
      nr = RCW'(MAX_RESOURCES);
    end else begin
      nr = RCW'(cfg_nr);
    end
  end

  assign p_idx = p[PW-1:0];
  assign r_idx = r[RW-1:0];

  // Load decode; out-of-range indexes write nothing
  assign amt_wide     = 32'(amount);
  assign amt          = amt_wide[AMOUNT_BITS-1:0];
  assign ld_proc_ok   = 32'(process) < 32'(MAX_PROCESSES);
  assign ld_res_ok    = 32'(resource) < 32'(MAX_RESOURCES);
  assign ld_addr_wide = 32'(process) * 32'(MAX_RESOURCES) + 32'(resource);
  assign ld_addr      = ld_addr_wide[SAW-1:0];
  assign ld_res_wide  = 32'(resource);
  assign ld_res_idx   = ld_res_wide[RW-1:0];

  assign run_addr_wide = 32'(p_idx) * 32'(MAX_RESOURCES) + 32'(r_idx);
  assign run_addr      = run_addr_wide[SAW-1:0];

  assign claim_we = cmd.load && (kind == KIND_CLAIM) && ld_proc_ok && ld_res_ok;
  assign alloc_we = cmd.load && (kind == KIND_ALLOC) && ld_proc_ok && ld_res_ok;
  assign avail_we = (cmd.load && (kind == KIND_AVAIL) && ld_res_ok) || cmd.wr_add;
  assign store_re = cmd.rd_chk || cmd.rd_add;

  // Release adds the allocation and wraps at the available width
  assign avail_sum   = avail_rd + AVAIL_BITS'(alloc_rd);
  assign avail_wdata = cmd.wr_add ? avail_sum : AVAIL_BITS'(amt);
  assign avail_waddr = cmd.wr_add ? r_idx : ld_res_idx;

  bsc_ram #(.WIDTH(AMOUNT_BITS), .DEPTH(SDEPTH)) u_claim (
    .clk   (clk),
    .we    (claim_we),
    .waddr (ld_addr),
    .wdata (amt),
    .re    (cmd.rd_chk),
    .raddr (run_addr),
    .rdata (claim_rd)
  );

  bsc_ram #(.WIDTH(AMOUNT_BITS), .DEPTH(SDEPTH)) u_alloc (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (ld_addr),
    .wdata (amt),
    .re    (store_re),
    .raddr (run_addr),
    .rdata (alloc_rd)
  );

  bsc_ram #(.WIDTH(AVAIL_BITS), .DEPTH(MAX_RESOURCES)) u_avail (
    .clk   (clk),
    .we    (avail_we),
    .waddr (avail_waddr),
    .wdata (avail_wdata),
    .re    (store_re),
    .raddr (r_idx),
    .rdata (avail_rd)
  );

  bsc_ram #(.WIDTH(PW), .DEPTH(MAX_PROCESSES)) u_order (
    .clk   (clk),
    .we    (cmd.pick),
    .waddr (count[PW-1:0]),
    .wdata (p_idx),
    .re    (cmd.rd_ord),
    .raddr (p_idx),
    .rdata (ord_rd)
  );

  // Signed need against the unsigned available count
  assign need    = $signed({1'b0, claim_rd}) - $signed({1'b0, alloc_rd});
  assign need_x  = (AVAIL_BITS + 1)'(need);
  assign avail_x = $signed({1'b0, avail_rd});

  always_comb begin
    stat.p_done   = (p == np);
    stat.p_flag   = flags[p_idx];
    stat.r_last   = (r == nr - RCW'(1));
    stat.fits     = !(need_x > avail_x);
    stat.all_done = (count == np);
    stat.p_last   = (p == np - PCW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p            <= '0;
      r            <= '0;
      count        <= '0;
      flags        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit || cmd.emit_dead;
      if (cmd.run_init) begin
        p     <= '0;
        r     <= '0;
        count <= '0;
        flags <= '0;
      end
      if (cmd.next_r) begin
        r <= r + RCW'(1);
      end
      if (cmd.next_p) begin
        p <= p + PCW'(1);
        r <= '0;
      end
      if (cmd.pick) begin
        flags[p_idx] <= 1'b1;
        count        <= count + PCW'(1);
        r            <= '0;
      end
      if (cmd.rescan) begin
        p <= '0;
        r <= '0;
      end
    end
  end

  assign ord_wide = 32'(ord_rd);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      verdict     <= 1'b0;
      process_res <= ord_wide[3:0];
      last        <= stat.p_last;
    end else if (cmd.emit_dead) begin
      verdict     <= 1'b1;
      process_res <= '0;
      last        <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/bankers_safety_check.sv =====
// Top level of the banker's safety check block: register port, controller, datapath.
//
//   port group  | direction | handshake
//   ------------+-----------+---------------------------------------------
//   config      | in/out    | APB write at psel & penable & pwrite; pready=1
//   item        | in        | taken when start is high and busy is low
//   result      | out       | one cycle wide, marked by result_valid
//
// Load items leave busy low. A run scans processes in index order, skipping
// a finished one and reading then comparing each resource of a candidate
// (one store read port per RAM), then reads and writes back each available
// count to release a pick, and rescans from process 0.
// Results are never held: the receiver cannot stall. Synchronous reset; no
// clearing pass.
`include "bankers_safety_check_assert.svh"

module bankers_safety_check import bsc_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
  parameter int AMOUNT_BITS   = AMOUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [3:0]            process,
  input  logic [3:0]            resource,
  input  logic [15:0]           amount,
  output logic                  result_valid,
  output logic                  verdict,
  output logic [3:0]            process_res,
  output logic                  last
);

  logic [CFG_BITS-1:0] num_processes, num_resources;
  logic                cfg_we;
  cmd_t                cmd;
  stat_t               stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_processes <= CFG_BITS'(1);
      num_resources <= CFG_BITS'(1);
    end else if (cfg_we) begin
      if (paddr[2] == REG_NUM_PROC) begin
        num_processes <= pwdata[CFG_BITS-1:0];
      end else begin
        num_resources <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NUM_RES) ? PDATA_BITS'(num_resources)
                                            : PDATA_BITS'(num_processes);

  bsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsc_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .AMOUNT_BITS   (AMOUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .process      (process),
    .resource     (resource),
    .amount       (amount),
    .cfg_np       (num_processes),
    .cfg_nr       (num_resources),
    .result_valid (result_valid),
    .verdict      (verdict),
    .process_res  (process_res),
    .last         (last)
  );

  `BSC_ASSERT_NOW(a_result_in_run, result_valid, $past(busy), "result outside a run")
  `BSC_ASSERT_NOW(a_dead_shape, result_valid && verdict, last && (process_res == 4'd0), "bad deadlock item")
  `BSC_ASSERT_NEXT(a_run_busy, start && !busy && (kind == KIND_RUN), busy, "run did not start")
  `BSC_ASSERT_NEXT(a_load_quiet, start && !busy && (kind != KIND_RUN), !busy && !result_valid, "load item misbehaved")

endmodule

// ===== tb/sv/bankers_safety_check_tb.sv =====
// Testbench for bankers_safety_check: directed and random traffic checked against a local predictor.
`timescale 1ns / 100ps

module bankers_safety_check_tb import bsc_pkg::*;;

  localparam logic [PADDR_BITS-1:0] ADDR_NUM_PROC = {REG_NUM_PROC, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_NUM_RES  = {REG_NUM_RES, 2'b00};
  localparam int NPROC = MAX_PROCESSES_DEF;
  localparam int NRES  = MAX_RESOURCES_DEF;
  localparam int FILL  = 4;

  typedef struct packed {
    logic       verdict;
    logic [3:0] proc;
    logic       last;
  } outcome_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            kind = KIND_CLAIM;
  logic [3:0]            proc_idx = '0;
  logic [3:0]            res_idx = '0;
  logic [15:0]           amount = '0;
  logic                  result_valid;
  logic                  verdict;
  logic [3:0]            process_res;
  logic                  last;

  // Predictor state
  logic [15:0] claim_mem [NPROC][NRES];
  logic [15:0] alloc_mem [NPROC][NRES];
  logic [20:0] avail_mem [NRES];
  bit          claim_set [NPROC][NRES];
  bit          alloc_set [NPROC][NRES];
  bit          avail_set [NRES];
  logic [4:0]  cfg_procs = 5'd1;
  logic [4:0]  cfg_res = 5'd1;
  outcome_t    pending_outcomes [$];
  outcome_t    head_outcome;

  int idle_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int safe_runs = 0;
  int deadlock_runs = 0;
  int mismatches = 0;

  bankers_safety_check dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .process     (proc_idx),
    .resource    (res_idx),
    .amount      (amount),
    .result_valid(result_valid),
    .verdict     (verdict),
    .process_res (process_res),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic note_mismatch(string what, int expv, int gotv);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expv, gotv);
  endtask

  function automatic int eff_count(logic [4:0] v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  // Rescan from process 0 after every pick; releases stay in the available store.
  task automatic predict_safe_order();
    int np, nr, done_cnt, need;
    logic [NPROC-1:0] fin;
    logic [3:0] order [NPROC];
    logic picked, ok;
    np = eff_count(cfg_procs, NPROC);
    nr = eff_count(cfg_res, NRES);
    fin = '0;
    done_cnt = 0;
    do begin
      picked = 1'b0;
      for (int i = 0; i < np && !picked; i++) begin
        if (!fin[i]) begin
          ok = 1'b1;
          for (int j = 0; j < nr; j++) begin
            need = int'(claim_mem[i][j]) - int'(alloc_mem[i][j]);
            if (need > int'(avail_mem[j])) ok = 1'b0;
          end
          if (ok) begin
            fin[i] = 1'b1;
            order[done_cnt] = 4'(i);
            done_cnt++;
            for (int j = 0; j < nr; j++) avail_mem[j] = avail_mem[j] + alloc_mem[i][j];
            picked = 1'b1;
          end
        end
      end
    end while (picked);
    if (done_cnt < np) begin
      pending_outcomes.push_back('{verdict: 1'b1, proc: 4'd0, last: 1'b1});
      deadlock_runs++;
    end else begin
      for (int k = 0; k < np; k++)
        pending_outcomes.push_back('{verdict: 1'b0, proc: order[k], last: (k == np - 1)});
      safe_runs++;
    end
  endtask

  task automatic track_item(kind_t k, logic [3:0] p, logic [3:0] r, logic [15:0] a);
    case (k)
      KIND_CLAIM: begin
        claim_mem[p][r] = a;
        claim_set[p][r] = 1'b1;
      end
      KIND_ALLOC: begin
        alloc_mem[p][r] = a;
        alloc_set[p][r] = 1'b1;
      end
      KIND_AVAIL: begin
        avail_mem[r] = {5'd0, a};
        avail_set[r] = 1'b1;
      end
      default: predict_safe_order();
    endcase
  endtask

  // Drive one item and hold it until the block takes it.
  task automatic send_item(kind_t k, logic [3:0] p, logic [3:0] r, logic [15:0] a);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    proc_idx <= p;
    res_idx <= r;
    amount <= a;
    do @(posedge clk); while (busy);
    track_item(k, p, r, a);
    items_sent++;
  endtask

  // Hold off new items until every expected result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_BITS-1:0] addr, logic [31:0] data);
    logic [4:0] stored;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    stored = data[4:0];
    if (addr == ADDR_NUM_PROC) cfg_procs = stored;
    else cfg_res = stored;
    // read back on the same select
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {27'd0, stored})
      note_mismatch("register readback", int'(stored), int'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] small_amount();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(12));
  endfunction

  function automatic logic [31:0] pick_reg_value();
    logic [31:0] v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) v = $urandom_range(5, 1);
    else if (sel < 85) v = $urandom_range(16, 6);
    else if (sel < 92) v = 0;
    else v = $urandom_range(31, 17);
    if ($urandom_range(7) == 0) v[31:5] = 27'($urandom);
    return v;
  endfunction

  // Load every entry the next run reads that has never been loaded.
  task automatic fill_unwritten();
    int np, nr;
    np = eff_count(cfg_procs, NPROC);
    nr = eff_count(cfg_res, NRES);
    for (int i = 0; i < np; i++) begin
      for (int j = 0; j < nr; j++) begin
        if (!claim_set[i][j]) send_item(KIND_CLAIM, 4'(i), 4'(j), small_amount());
        if (!alloc_set[i][j])
          send_item(KIND_ALLOC, 4'(i), 4'(j), 16'($urandom_range(int'(claim_mem[i][j]))));
      end
    end
    for (int j = 0; j < nr; j++)
      if (!avail_set[j]) send_item(KIND_AVAIL, 4'd0, 4'(j), small_amount());
  endtask

  task automatic send_run();
    fill_unwritten();
    send_item(KIND_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("result with nothing expected", 0, int'({verdict, process_res, last}));
      end else begin
        head_outcome = pending_outcomes.pop_front();
        results_seen++;
        if (verdict !== head_outcome.verdict)
          note_mismatch("verdict", int'(head_outcome.verdict), int'(verdict));
        if (process_res !== head_outcome.proc)
          note_mismatch("process_res", int'(head_outcome.proc), int'(process_res));
        if (last !== head_outcome.last)
          note_mismatch("last", int'(head_outcome.last), int'(last));
      end
    end
  end

  // Load a corner of the stores; each run loads any other entry it reads first.
  task automatic test_store_fill();
    logic [15:0] c;
    for (int p = 0; p < FILL; p++) begin
      for (int r = 0; r < FILL; r++) begin
        c = small_amount();
        send_item(KIND_CLAIM, 4'(p), 4'(r), c);
        send_item(KIND_ALLOC, 4'(p), 4'(r), 16'($urandom_range(c)));
      end
    end
    for (int r = 0; r < FILL; r++) send_item(KIND_AVAIL, 4'd0, 4'(r), small_amount());
  endtask

  // Reset register values: one process, one resource.
  task automatic test_single_process();
    send_item(KIND_CLAIM, 4'd0, 4'd0, 16'd0);
    send_item(KIND_ALLOC, 4'd0, 4'd0, 16'd0);
    send_item(KIND_AVAIL, 4'd0, 4'd0, 16'd0);
    send_run();
    send_item(KIND_CLAIM, 4'd0, 4'd0, 16'hFFFF);
    send_run();
    // need below zero always fits
    send_item(KIND_ALLOC, 4'd0, 4'd0, 16'hFFFF);
    send_item(KIND_CLAIM, 4'd0, 4'd0, 16'd0);
    send_run();
  endtask

  // Counts at and beyond their limits, for processes and for resources.
  task automatic test_register_limits();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd0);
    write_reg(ADDR_NUM_RES, 32'd0);
    send_run();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd16);
    write_reg(ADDR_NUM_RES, 32'd1);
    send_run();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd1);
    write_reg(ADDR_NUM_RES, 32'd16);
    send_run();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd31);
    write_reg(ADDR_NUM_RES, 32'd0);
    send_run();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd0);
    write_reg(ADDR_NUM_RES, 32'd17);
    send_run();
    drain();
    write_reg(ADDR_NUM_PROC, 32'hFFFF_FFE2);
    write_reg(ADDR_NUM_RES, 32'hFFFF_FFE1);
    send_run();
  endtask

  // Order comes out 2, 0, 1: a later process frees what earlier ones need.
  task automatic test_pick_order();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd3);
    write_reg(ADDR_NUM_RES, 32'd1);
    send_item(KIND_CLAIM, 4'd0, 4'd0, 16'd3);
    send_item(KIND_ALLOC, 4'd0, 4'd0, 16'd1);
    send_item(KIND_CLAIM, 4'd1, 4'd0, 16'd3);
    send_item(KIND_ALLOC, 4'd1, 4'd0, 16'd0);
    send_item(KIND_CLAIM, 4'd2, 4'd0, 16'd2);
    send_item(KIND_ALLOC, 4'd2, 4'd0, 16'd1);
    send_item(KIND_AVAIL, 4'd0, 4'd0, 16'd1);
    send_run();
  endtask

  // Two runs of full releases bring the available count to exactly 2^21;
  // the final run deadlocks only if the count wrapped to zero.
  task automatic test_avail_wrap();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd31);
    for (int p = 0; p < NPROC; p++) send_item(KIND_ALLOC, 4'(p), 4'd0, 16'hFFFF);
    send_item(KIND_AVAIL, 4'd0, 4'd0, 16'h0020);
    send_run();
    send_run();
    drain();
    write_reg(ADDR_NUM_PROC, 32'd1);
    send_item(KIND_CLAIM, 4'd0, 4'd0, 16'hFFFF);
    send_item(KIND_ALLOC, 4'd0, 4'd0, 16'd0);
    send_run();
  endtask

  task automatic random_sequence();
    int sel, np, nr, p, r;
    logic [15:0] c;
    sel = $urandom_range(99);
    if (sel < 12) begin
      drain();
      write_reg(ADDR_NUM_PROC, pick_reg_value());
      // keep the loaded area small when many processes take part
      write_reg(ADDR_NUM_RES, (eff_count(cfg_procs, NPROC) > 3) ?
                32'($urandom_range(2)) : pick_reg_value());
    end
    np = eff_count(cfg_procs, NPROC);
    nr = eff_count(cfg_res, NRES);
    if (sel >= 12 && sel < 30) begin
      // noise: loads anywhere with full-range fields
      repeat ($urandom_range(3, 1))
        send_item(kind_t'($urandom_range(2)), 4'($urandom), 4'($urandom), 16'($urandom));
      if ($urandom_range(1)) send_run();
      return;
    end
    if ($urandom_range(99) < 70)
      for (int j = 0; j < nr; j++) send_item(KIND_AVAIL, 4'($urandom), 4'(j), small_amount());
    if (np * nr <= 16 && $urandom_range(99) < 40) begin
      for (int i = 0; i < np; i++) begin
        for (int j = 0; j < nr; j++) begin
          c = small_amount();
          send_item(KIND_CLAIM, 4'(i), 4'(j), c);
          send_item(KIND_ALLOC, 4'(i), 4'(j), 16'($urandom_range(c)));
        end
      end
    end else begin
      repeat ($urandom_range(6)) begin
        p = $urandom_range(np - 1);
        r = $urandom_range(nr - 1);
        c = small_amount();
        send_item(KIND_CLAIM, 4'(p), 4'(r), c);
        send_item(KIND_ALLOC, 4'(p), 4'(r),
                  ($urandom_range(9) == 0) ? small_amount() : 16'($urandom_range(c)));
      end
    end
    if ($urandom_range(9) == 0) drain();
    send_run();
    if ($urandom_range(4) == 0) send_run();
  endtask

  task automatic test_random_traffic();
    int target;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 65;
        default: idle_pct = 9;
      endcase
      target = items_sent + 20;
      while (items_sent < target) random_sequence();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_store_fill();
    test_single_process();
    test_register_limits();
    test_pick_order();
    test_avail_wrap();
    test_random_traffic();
    drain();
    $display("Sent %0d items: %0d safety checks, %0d safe and %0d deadlocked.",
             items_sent, safe_runs + deadlock_runs, safe_runs, deadlock_runs);
    $display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
